// ===== rtl/pid_controller_clamped_top_macros.svh =====
// Assertion helpers shared by the PID datapath modules.
// Define ASSERT_OFF to compile all checks out.
`ifndef PID_CONTROLLER_CLAMPED_TOP_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset
`define PIDC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pidc: assertion failed");

// Boolean condition must never be seen outside reset
`define PIDC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pidc: forbidden condition seen");

`else

`define PIDC_ASSERT(lbl, clk, rst_n, prop)
`define PIDC_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/pidc_pkg.sv =====
package pidc_pkg;

  // Configuration port geometry
  localparam int unsigned CfgWidth    = 32;
  localparam int unsigned CfgIdxWidth = 3;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_PROP_GAIN = 3'd0,
    REG_INT_GAIN  = 3'd1,
    REG_DER_GAIN  = 3'd2,
    REG_DER_DECAY = 3'd3,
    REG_OUT_MAX   = 3'd4,
    REG_OUT_MIN   = 3'd5
  } reg_idx_e;

  // Reset values of the output limits (full Q16.16 range)
  localparam logic signed [CfgWidth-1:0] OutMaxReset = 32'sh7FFF_FFFF;
  localparam logic signed [CfgWidth-1:0] OutMinReset = 32'sh8000_0000;

  // Gains are Q8.24: a gain times a count drops 8 fraction bits to reach Q16.16
  localparam int unsigned GainShift  = 8;
  // Decay is Q0.32: decay times a Q16.16 value drops 32 bits
  localparam int unsigned DecayShift = 32;

  // Configuration register set
  typedef struct packed {
    logic signed [CfgWidth-1:0] prop_gain;
    logic signed [CfgWidth-1:0] int_gain;
    logic signed [CfgWidth-1:0] der_gain;
    logic        [CfgWidth-1:0] der_decay;
    logic signed [CfgWidth-1:0] out_max;
    logic signed [CfgWidth-1:0] out_min;
  } cfg_t;

  // Saturate a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/pidc_cfg.sv =====
// Configuration register file, write only
module pidc_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pidc_pkg::CfgIdxWidth-1:0]    cfg_addr_i,
  input  logic [pidc_pkg::CfgWidth-1:0]       cfg_wdata_i,
  output pidc_pkg::cfg_t                      cfg_o
);

  pidc_pkg::cfg_t cfg_q;

  // Register writes by index; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain <= '0;
      cfg_q.int_gain  <= '0;
      cfg_q.der_gain  <= '0;
      cfg_q.der_decay <= '0;
      cfg_q.out_max   <= pidc_pkg::OutMaxReset;
      cfg_q.out_min   <= pidc_pkg::OutMinReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        pidc_pkg::REG_PROP_GAIN: cfg_q.prop_gain <= cfg_wdata_i;
        pidc_pkg::REG_INT_GAIN:  cfg_q.int_gain  <= cfg_wdata_i;
        pidc_pkg::REG_DER_GAIN:  cfg_q.der_gain  <= cfg_wdata_i;
        pidc_pkg::REG_DER_DECAY: cfg_q.der_decay <= cfg_wdata_i;
        pidc_pkg::REG_OUT_MAX:   cfg_q.out_max   <= cfg_wdata_i;
        pidc_pkg::REG_OUT_MIN:   cfg_q.out_min   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/pidc_front.sv =====
`include "pid_controller_clamped_top_macros.svh"

// Input register (error terms) followed by the gain product stage
module pidc_front #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pidc_pkg::cfg_t                    cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [SAMPLE_BITS-1:0]            target_i,
  input  logic [SAMPLE_BITS-1:0]            measured_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_BITS+24:0]    prop_o,
  output logic signed [SAMPLE_BITS+25:0]    integ_step_o,
  output logic signed [SAMPLE_BITS+24:0]    der_step_o
);

  localparam int unsigned Sb = SAMPLE_BITS;

  // Stage A: error, error pair sum, measurement change
  logic                    va_q;
  logic signed [Sb:0]      err_d, err_q;
  logic signed [Sb+1:0]    esum_d, esum_q;
  logic signed [Sb:0]      dmeas_d, dmeas_q;
  logic signed [Sb:0]      last_err_q;
  logic        [Sb-1:0]    last_meas_q;
  logic                    a_rdy, in_xfer;

  // Stage B: products brought to Q16.16 (floor by dropping low bits)
  logic                    vb_q;
  logic signed [Sb+32:0]   p_full, dg_full;
  logic signed [Sb+33:0]   ig_full;
  logic signed [Sb+24:0]   p_q, dg_q;
  logic signed [Sb+25:0]   ig_q;
  logic                    b_rdy;

  assign b_rdy      = !vb_q || out_ready_i;
  assign a_rdy      = !va_q || b_rdy;
  assign in_ready_o = a_rdy;
  assign in_xfer    = in_valid_i && a_rdy;

  assign err_d   = $signed({1'b0, target_i}) - $signed({1'b0, measured_i});
  assign esum_d  = $signed({err_d[Sb], err_d}) + $signed({last_err_q[Sb], last_err_q});
  assign dmeas_d = $signed({1'b0, measured_i}) - $signed({1'b0, last_meas_q});

  // Previous error and sample follow every accepted transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q  <= '0;
      last_meas_q <= '0;
    end else if (in_xfer) begin
      last_err_q  <= err_d;
      last_meas_q <= measured_i;
    end
  end

  // Stage A valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (a_rdy) begin
      va_q <= in_valid_i;
    end
  end

  // Stage A payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      err_q   <= err_d;
      esum_q  <= esum_d;
      dmeas_q <= dmeas_d;
    end
  end

  // Gain products
  assign p_full  = cfg_i.prop_gain * err_q;
  assign ig_full = cfg_i.int_gain * esum_q;
  assign dg_full = cfg_i.der_gain * dmeas_q;

  // Stage B valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (b_rdy) begin
      vb_q <= va_q;
    end
  end

  // Stage B payload
  always_ff @(posedge clk_i) begin
    if (b_rdy && va_q) begin
      p_q  <= p_full[Sb+32:pidc_pkg::GainShift];
      ig_q <= ig_full[Sb+33:pidc_pkg::GainShift];
      dg_q <= dg_full[Sb+32:pidc_pkg::GainShift];
    end
  end

  assign out_valid_o  = vb_q;
  assign prop_o       = p_q;
  assign integ_step_o = ig_q;
  assign der_step_o   = dg_q;

  // An accepted transfer always lands in stage A
  `PIDC_ASSERT(a_front_load, clk_i, rst_ni, in_xfer |=> va_q)
  // Full pipe against a stalled sink must hold off the source
  `PIDC_ASSERT_NEVER(a_front_block, clk_i, rst_ni, va_q && vb_q && !out_ready_i && in_ready_o)

endmodule

// ===== rtl/pidc_update.sv =====
`include "pid_controller_clamped_top_macros.svh"

// Integrator and derivative filter update with headroom clamp
module pidc_update #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pidc_pkg::cfg_t                    cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_BITS+24:0]    prop_i,
  input  logic signed [SAMPLE_BITS+25:0]    integ_step_i,
  input  logic signed [SAMPLE_BITS+24:0]    der_step_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_BITS+24:0]    prop_o,
  output logic signed [31:0]                integ_o,
  output logic signed [31:0]                deriv_o
);

  localparam int unsigned Sb = SAMPLE_BITS;

  logic                    vc_q, c_rdy, load;
  logic signed [Sb+24:0]   p_q;
  logic signed [31:0]      int_q, filt_q;
  logic signed [31:0]      int_d, filt_d;

  // Derivative filter
  logic signed [64:0]      dec_full;
  logic signed [32:0]      dec_sh;
  logic signed [Sb+25:0]   d_wide;

  // Headroom and integrator
  logic signed [Sb+25:0]   max_x, min_x, p_x, hi, lo;
  logic signed [Sb+26:0]   int_wide, int_clamp;

  assign c_rdy      = !vc_q || out_ready_i;
  assign in_ready_o = c_rdy;
  assign load       = c_rdy && in_valid_i;

  // decay * old filter value, Q.48 floored to Q16.16, minus the gain step
  assign dec_full = $signed({1'b0, cfg_i.der_decay}) * filt_q;
  assign dec_sh   = dec_full[64:pidc_pkg::DecayShift];
  assign d_wide   = $signed({{(Sb-7){dec_sh[32]}}, dec_sh})
                  - $signed({der_step_i[Sb+24], der_step_i});
  assign filt_d   = pidc_pkg::sat32(64'(d_wide));

  // Headroom left for the integrator beside the proportional term
  assign max_x = $signed({{(Sb-6){cfg_i.out_max[31]}}, cfg_i.out_max});
  assign min_x = $signed({{(Sb-6){cfg_i.out_min[31]}}, cfg_i.out_min});
  assign p_x   = $signed({prop_i[Sb+24], prop_i});
  assign hi    = (max_x > p_x) ? max_x - p_x : '0;
  assign lo    = (min_x < p_x) ? min_x - p_x : '0;

  // Trapezoid integrator, upper bound tested first, then saturate
  assign int_wide = $signed({{(Sb-5){int_q[31]}}, int_q})
                  + $signed({integ_step_i[Sb+25], integ_step_i});

  always_comb begin
    if (int_wide > $signed({hi[Sb+25], hi})) begin
      int_clamp = $signed({hi[Sb+25], hi});
    end else if (int_wide < $signed({lo[Sb+25], lo})) begin
      int_clamp = $signed({lo[Sb+25], lo});
    end else begin
      int_clamp = int_wide;
    end
  end

  assign int_d = pidc_pkg::sat32(64'(int_clamp));

  // Stage C valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (c_rdy) begin
      vc_q <= in_valid_i;
    end
  end

  // Controller state, advanced once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q  <= '0;
      filt_q <= '0;
    end else if (load) begin
      int_q  <= int_d;
      filt_q <= filt_d;
    end
  end

  // Proportional term travels along
  always_ff @(posedge clk_i) begin
    if (load) begin
      p_q <= prop_i;
    end
  end

  assign out_valid_o = vc_q;
  assign prop_o      = p_q;
  assign integ_o     = int_q;
  assign deriv_o     = filt_q;

  // Stored integrator lies inside the headroom of its own item
  `PIDC_ASSERT(a_upd_headroom, clk_i, rst_ni,
    load |=> (int_q <= $past(hi) && int_q >= $past(lo)))
  // State only moves when an item enters this stage
  `PIDC_ASSERT(a_upd_hold, clk_i, rst_ni,
    !load |=> ($stable(int_q) && $stable(filt_q)))

endmodule

// ===== rtl/pidc_out.sv =====
`include "pid_controller_clamped_top_macros.svh"

// Term sum, output clamp and result register
module pidc_out #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pidc_pkg::cfg_t                    cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_BITS+24:0]    prop_i,
  input  logic signed [31:0]                integ_i,
  input  logic signed [31:0]                deriv_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [31:0]                drive_o,
  output logic                              limited_o
);

  localparam int unsigned Sb = SAMPLE_BITS;

  logic                    vd_q, d_rdy, load;
  logic signed [Sb+26:0]   sum, max_x, min_x;
  logic signed [31:0]      drive_d, drive_q;
  logic                    lim_d, lim_q;

  assign d_rdy      = !vd_q || out_ready_i;
  assign in_ready_o = d_rdy;
  assign load       = d_rdy && in_valid_i;

  // Exact three-term sum
  assign sum = $signed({{2{prop_i[Sb+24]}}, prop_i})
             + $signed({{(Sb-5){integ_i[31]}}, integ_i})
             + $signed({{(Sb-5){deriv_i[31]}}, deriv_i});

  assign max_x = $signed({{(Sb-5){cfg_i.out_max[31]}}, cfg_i.out_max});
  assign min_x = $signed({{(Sb-5){cfg_i.out_min[31]}}, cfg_i.out_min});

  // Upper limit tested first, then lower
  always_comb begin
    if (sum > max_x) begin
      drive_d = cfg_i.out_max;
      lim_d   = 1'b1;
    end else if (sum < min_x) begin
      drive_d = cfg_i.out_min;
      lim_d   = 1'b1;
    end else begin
      drive_d = sum[31:0];
      lim_d   = 1'b0;
    end
  end

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (d_rdy) begin
      vd_q <= in_valid_i;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      drive_q <= drive_d;
      lim_q   <= lim_d;
    end
  end

  assign out_valid_o = vd_q;
  assign drive_o     = drive_q;
  assign limited_o   = lim_q;

  // With ordered limits a fresh result lies within them
  `PIDC_ASSERT(a_out_range, clk_i, rst_ni,
    (load && cfg_i.out_min <= cfg_i.out_max) |=>
      (drive_q <= $past(cfg_i.out_max) && drive_q >= $past(cfg_i.out_min)))

endmodule

// ===== rtl/pid_controller_clamped_top.sv =====
// Channel   Dir  tdata (low bit up)            tuser
// --------  ---  ----------------------------  ---------------
// s_axis    in   target, measured, zero pad    -
// m_axis    out  drive (Q16.16)                limited
// cfg       in   write: cfg_we_i/addr/wdata    -
//
// One item per clock sustained while m_axis_tready stays high; each sample passes
// the error register, gain products, state update and result register before
// m_axis_tvalid rises with its result.
// The loop that sets the clock is the filter update: a 33x32 multiply of the
// decay by the previous filter value, a subtract and a saturate.
// Reset clears the pipeline, the integrator, filter and previous sample/error,
// and loads the gains with zero and the limits with the full range.
// A stall on m_axis holds each full stage; s_axis_tready stays high while
// any stage ahead still has a bubble.
module pid_controller_clamped_top #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration
  input  logic                                   cfg_we_i,
  input  logic [pidc_pkg::CfgIdxWidth-1:0]       cfg_addr_i,
  input  logic [pidc_pkg::CfgWidth-1:0]          cfg_wdata_i,
  // input stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // target, measured, zero pad to bytes
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // result stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // drive
  output logic [31:0]                            m_axis_tdata,
  // limited
  output logic                                   m_axis_tuser
);

  localparam int unsigned Sb = SAMPLE_BITS;

  pidc_pkg::cfg_t          cfg;

  logic                    ab_valid, ab_ready;
  logic signed [Sb+24:0]   ab_prop, ab_der;
  logic signed [Sb+25:0]   ab_integ;

  logic                    cd_valid, cd_ready;
  logic signed [Sb+24:0]   cd_prop;
  logic signed [31:0]      cd_integ, cd_deriv;

  logic signed [31:0]      drive;

  pidc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pidc_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .target_i     (s_axis_tdata[Sb-1:0]),
    .measured_i   (s_axis_tdata[2*Sb-1:Sb]),
    .out_valid_o  (ab_valid),
    .out_ready_i  (ab_ready),
    .prop_o       (ab_prop),
    .integ_step_o (ab_integ),
    .der_step_o   (ab_der)
  );

  pidc_update #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_update (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (ab_valid),
    .in_ready_o   (ab_ready),
    .prop_i       (ab_prop),
    .integ_step_i (ab_integ),
    .der_step_i   (ab_der),
    .out_valid_o  (cd_valid),
    .out_ready_i  (cd_ready),
    .prop_o       (cd_prop),
    .integ_o      (cd_integ),
    .deriv_o      (cd_deriv)
  );

  pidc_out #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (cd_valid),
    .in_ready_o  (cd_ready),
    .prop_i      (cd_prop),
    .integ_i     (cd_integ),
    .deriv_i     (cd_deriv),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .drive_o     (drive),
    .limited_o   (m_axis_tuser)
  );

  assign m_axis_tdata = drive;

endmodule

// ===== verif/pid_controller_clamped_top_tb.sv =====
`timescale 1ns / 1ps

module pid_controller_clamped_top_tb;

  localparam int SampleBits    = 10;
  localparam int TdataWidth    = ((2 * SampleBits + 7) / 8) * 8;
  localparam int ResetCycles   = 10;
  localparam int HoldCycles    = 60;
  localparam int DrainCycles   = 8;
  localparam int IdleLimit     = 2000;
  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 50;
  // phases with special handshake behavior
  localparam int QuietPhase    = 0;
  localparam int HoldPhase     = 2;
  localparam int PausePhase    = 3;

  // indexes the block has no register for
  localparam logic [pidc_pkg::CfgIdxWidth-1:0] RegSpareLo = 3'd6;
  localparam logic [pidc_pkg::CfgIdxWidth-1:0] RegSpareHi = 3'd7;

  localparam longint WordMax = 2147483647;
  localparam longint WordMin = -WordMax - 1;

  typedef struct packed {
    logic [31:0] drive;
    logic        limited;
  } pid_result_t;

  typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e                        kind;
    logic [pidc_pkg::CfgIdxWidth-1:0] idx;
    logic [31:0]                      wdata;
    logic [SampleBits-1:0]            tgt;
    logic [SampleBits-1:0]            meas;
    bit                               typed;
    logic [31:0]                      drive;
    logic                             limited;
  } plan_row_t;

  // Directed plan: register writes and samples; typed results where obvious
  localparam int NumDirRows = 45;
  localparam plan_row_t DirPlan [NumDirRows] = '{
    // first sample: derivative sees the whole sample as its change
    '{ROW_WRITE, pidc_pkg::REG_DER_GAIN, 32'h0100_0000, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd512, 10'd1023, 1'b1, 32'hFC01_0000, 1'b0},
    // all gains zero
    '{ROW_WRITE, pidc_pkg::REG_DER_GAIN, 32'h0, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd1023, 10'd0, 1'b1, 32'h0, 1'b0},
    // unity proportional gain, full-scale errors
    '{ROW_WRITE, pidc_pkg::REG_PROP_GAIN, 32'h0100_0000, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd1023, 10'd0, 1'b1, 32'h03FF_0000, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd0, 10'd1023, 1'b1, 32'hFC01_0000, 1'b0},
    // narrow limits: clamp high, clamp low, zero error
    '{ROW_WRITE, pidc_pkg::REG_OUT_MAX, 32'h0001_0000, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidc_pkg::REG_OUT_MIN, 32'hFFFF_0000, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd1023, 10'd0, 1'b1, 32'h0001_0000, 1'b1},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd0, 10'd1023, 1'b1, 32'hFFFF_0000, 1'b1},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd5, 10'd5, 1'b1, 32'h0, 1'b0},
    // crossed limits: upper test wins
    '{ROW_WRITE, pidc_pkg::REG_OUT_MAX, 32'hFFFF_0000, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidc_pkg::REG_OUT_MIN, 32'h0001_0000, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd7, 10'd7, 1'b1, 32'hFFFF_0000, 1'b1},
    // extreme proportional gains against full-range limits
    '{ROW_WRITE, pidc_pkg::REG_OUT_MAX, 32'h7FFF_FFFF, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidc_pkg::REG_OUT_MIN, 32'h8000_0000, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidc_pkg::REG_PROP_GAIN, 32'h7FFF_FFFF, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd1023, 10'd0, 1'b1, 32'h7FFF_FFFF, 1'b1},
    '{ROW_WRITE, pidc_pkg::REG_PROP_GAIN, 32'h8000_0000, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd1023, 10'd0, 1'b1, 32'h8000_0000, 1'b1},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd0, 10'd1023, 1'b1, 32'h7FFF_FFFF, 1'b1},
    // max integral gain: headroom clamp; writes to unmapped indexes dropped
    '{ROW_WRITE, pidc_pkg::REG_PROP_GAIN, 32'h0040_0000, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidc_pkg::REG_INT_GAIN, 32'h7FFF_FFFF, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, RegSpareLo, 32'hDEAD_BEEF, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, RegSpareHi, 32'h1234_5678, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd1023, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd1023, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd300, 10'd700, 1'b0, 32'h0, 1'b0},
    // min integral gain
    '{ROW_WRITE, pidc_pkg::REG_INT_GAIN, 32'h8000_0000, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd0, 10'd1023, 1'b0, 32'h0, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd1023, 10'd0, 1'b0, 32'h0, 1'b0},
    // max derivative gain and decay: filter saturation
    '{ROW_WRITE, pidc_pkg::REG_INT_GAIN, 32'h0001_0000, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidc_pkg::REG_DER_GAIN, 32'h7FFF_FFFF, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidc_pkg::REG_DER_DECAY, 32'hFFFF_FFFF, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd0, 10'd1023, 1'b0, 32'h0, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    // min derivative gain, half decay
    '{ROW_WRITE, pidc_pkg::REG_DER_GAIN, 32'h8000_0000, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidc_pkg::REG_DER_DECAY, 32'h8000_0000, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd1023, 10'd1023, 1'b0, 32'h0, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd1023, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd512, 10'd511, 1'b0, 32'h0, 1'b0},
    '{ROW_SAMPLE, pidc_pkg::REG_PROP_GAIN, 32'h0, 10'd1, 10'd1022, 1'b0, 32'h0, 1'b0}
  };

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [pidc_pkg::CfgIdxWidth-1:0] cfg_addr_i;
  logic [pidc_pkg::CfgWidth-1:0]    cfg_wdata_i;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [TdataWidth-1:0]            s_axis_tdata;   // target, measured, zero pad
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [31:0]                      m_axis_tdata;   // drive
  logic                             m_axis_tuser;   // limited

  // typed result riding along with the sample on the bus
  bit                     row_check;
  logic [31:0]            row_drive;
  logic                   row_limited;

  // handshake shaping
  bit                     quiet;
  bit                     hold_req;

  // controller copy: registers and loop state
  logic signed [31:0]     gain_prop = '0;
  logic signed [31:0]     gain_int  = '0;
  logic signed [31:0]     gain_der  = '0;
  logic        [31:0]     der_decay = '0;
  logic signed [31:0]     drive_max = pidc_pkg::OutMaxReset;
  logic signed [31:0]     drive_min = pidc_pkg::OutMinReset;
  longint                 acc_int   = 0;
  longint                 err_prev  = 0;
  longint                 der_filt  = 0;
  longint                 meas_prev = 0;

  pid_result_t            pending_q [$];
  int unsigned            mismatch_cnt;
  int unsigned            clamped_cnt;
  int unsigned            idle_cycles;
  int unsigned            directed_cnt;
  int unsigned            random_cnt;
  int unsigned            settings_cnt;

  pid_controller_clamped_top #(
    .SAMPLE_BITS(SampleBits)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  function automatic longint clip_word(input longint v);
    if (v > WordMax) return WordMax;
    if (v < WordMin) return WordMin;
    return v;
  endfunction

  function automatic void set_register(input logic [pidc_pkg::CfgIdxWidth-1:0] idx,
                                       input logic [31:0] val);
    case (idx)
      pidc_pkg::REG_PROP_GAIN: gain_prop = val;
      pidc_pkg::REG_INT_GAIN:  gain_int  = val;
      pidc_pkg::REG_DER_GAIN:  gain_der  = val;
      pidc_pkg::REG_DER_DECAY: der_decay = val;
      pidc_pkg::REG_OUT_MAX:   drive_max = val;
      pidc_pkg::REG_OUT_MIN:   drive_min = val;
      default: ;
    endcase
  endfunction

  // One control update: P, trapezoid integrator with headroom clamp,
  // filtered derivative on the measurement, clamped sum
  function automatic pid_result_t ctrl_model_step(input logic [SampleBits-1:0] tgt,
                                                  input logic [SampleBits-1:0] meas);
    longint err, p, integ, hi, lo, d, sum;
    pid_result_t r;
    err = longint'(tgt) - longint'(meas);
    p = (longint'(gain_prop) * err) >>> pidc_pkg::GainShift;
    integ = acc_int + ((longint'(gain_int) * (err + err_prev)) >>> pidc_pkg::GainShift);
    d = ((longint'(der_decay) * der_filt) >>> pidc_pkg::DecayShift)
        - ((longint'(gain_der) * (longint'(meas) - meas_prev)) >>> pidc_pkg::GainShift);
    d = clip_word(d);
    hi = (longint'(drive_max) > p) ? longint'(drive_max) - p : 0;
    lo = (longint'(drive_min) < p) ? longint'(drive_min) - p : 0;
    if (integ > hi) begin
      integ = hi;
    end else if (integ < lo) begin
      integ = lo;
    end
    integ = clip_word(integ);
    sum = p + integ + d;
    r.limited = 1'b0;
    if (sum > longint'(drive_max)) begin
      sum = drive_max;
      r.limited = 1'b1;
    end else if (sum < longint'(drive_min)) begin
      sum = drive_min;
      r.limited = 1'b1;
    end
    acc_int   = integ;
    der_filt  = d;
    err_prev  = err;
    meas_prev = meas;
    r.drive = sum[31:0];
    return r;
  endfunction

  // Bus monitor: register writes, sample transfers, result checks, watchdog
  always @(posedge clk_i) begin : monitor
    pid_result_t want;
    pid_result_t calc;
    if (rst_ni) begin
      if (cfg_we_i) begin
        set_register(cfg_addr_i, cfg_wdata_i);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        calc = ctrl_model_step(s_axis_tdata[SampleBits-1:0],
                               s_axis_tdata[2*SampleBits-1:SampleBits]);
        if (row_check) begin
          calc.drive   = row_drive;
          calc.limited = row_limited;
        end
        pending_q.push_back(calc);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (m_axis_tuser === 1'b1) clamped_cnt++;
        if (pending_q.size() == 0) begin
          $error("drive transfer with no sample outstanding: drive %h limited %b",
                 m_axis_tdata, m_axis_tuser);
          mismatch_cnt++;
        end else begin
          want = pending_q.pop_front();
          if (m_axis_tdata !== want.drive) begin
            $error("drive: expected %h, actual %h", want.drive, m_axis_tdata);
            mismatch_cnt++;
          end
          if (m_axis_tuser !== want.limited) begin
            $error("limited: expected %b, actual %b", want.limited, m_axis_tuser);
            mismatch_cnt++;
          end
        end
      end
      // watchdog on cycles with no transfer on either stream
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Result side: random backpressure, quiet stretch, long hold-off on request
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (quiet) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 19);
      end
    end
  end

  task automatic send_sample(input logic [SampleBits-1:0] tgt,
                             input logic [SampleBits-1:0] meas,
                             input bit typed, input logic [31:0] drv, input logic lim);
    cfg_we_i <= 1'b0;
    if (!quiet) begin
      while ($urandom_range(99) < 19) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(TdataWidth - 2 * SampleBits){1'b0}}, meas, tgt};
    row_check     <= typed;
    row_drive     <= drv;
    row_limited   <= lim;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_q.size() != 0);
  endtask

  task automatic cfg_write(input logic [pidc_pkg::CfgIdxWidth-1:0] idx,
                           input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic write_settings(input logic [31:0] kp, input logic [31:0] ki,
                                input logic [31:0] kd, input logic [31:0] dec,
                                input logic [31:0] omax, input logic [31:0] omin);
    cfg_write(pidc_pkg::REG_PROP_GAIN, kp);
    cfg_write(pidc_pkg::REG_INT_GAIN, ki);
    cfg_write(pidc_pkg::REG_DER_GAIN, kd);
    cfg_write(pidc_pkg::REG_DER_DECAY, dec);
    cfg_write(pidc_pkg::REG_OUT_MAX, omax);
    cfg_write(pidc_pkg::REG_OUT_MIN, omin);
    if ($urandom_range(1) == 0) cfg_write($urandom_range(1) ? RegSpareHi : RegSpareLo, $urandom);
    settings_cnt++;
  endtask

  // Gains: mostly near unity or smaller so the loop does not always clamp
  function automatic logic [31:0] pick_gain();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return 32'($urandom_range(32'h0200_0000)) - 32'h0100_0000;
      default: return 32'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_decay();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return '0;
      default: return 32'hF000_0000 | 32'($urandom_range(32'h0FFF_FFFF));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned r, n, phase;
    int setpoint, meas_walk, delta;
    bit prev_sample;
    logic [SampleBits-1:0] tgt, meas;
    logic [31:0] omax, omin;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = pidc_pkg::REG_PROP_GAIN;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    row_check     = 1'b0;
    row_drive     = '0;
    row_limited   = 1'b0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed plan
    prev_sample = 1'b1;
    for (r = 0; r < NumDirRows; r++) begin
      if (DirPlan[r].kind == ROW_WRITE) begin
        if (prev_sample) wait_drained();
        cfg_write(DirPlan[r].idx, DirPlan[r].wdata);
        prev_sample = 1'b0;
      end else begin
        send_sample(DirPlan[r].tgt, DirPlan[r].meas, DirPlan[r].typed,
                    DirPlan[r].drive, DirPlan[r].limited);
        prev_sample = 1'b1;
        directed_cnt++;
      end
    end

    // random phases: mostly a measurement tracking a setpoint, some noise
    setpoint  = 512;
    meas_walk = 512;
    for (phase = 0; phase < NumPhases; phase++) begin
      wait_drained();
      quiet = (phase == QuietPhase);
      case (phase)
        0: write_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                          32'h7FFF_FFFF, 32'h8000_0000);
        1: write_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0,
                          32'h8000_0000, 32'h7FFF_FFFF);
        default: begin
          omax = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(32'h0400_0000));
          omin = ($urandom_range(3) == 0) ? $urandom : -32'($urandom_range(32'h0400_0000));
          write_settings(pick_gain(), pick_gain(), pick_gain(), pick_decay(), omax, omin);
        end
      endcase
      for (n = 0; n < ItemsPerPhase; n++) begin
        if (phase == HoldPhase && n == 10) hold_req = 1'b1;
        if (phase == PausePhase && n == 25) wait_drained();
        if ($urandom_range(9) < 7) begin
          if ($urandom_range(19) == 0) setpoint = $urandom_range(1023);
          delta = int'($urandom_range(32)) - 16;
          meas_walk += delta;
          if (meas_walk < 0) meas_walk = 0;
          if (meas_walk > 1023) meas_walk = 1023;
          tgt  = setpoint[SampleBits-1:0];
          meas = meas_walk[SampleBits-1:0];
        end else begin
          tgt  = SampleBits'($urandom_range(1023));
          meas = SampleBits'($urandom_range(1023));
        end
        send_sample(tgt, meas, 1'b0, '0, 1'b0);
        random_cnt++;
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d directed and %0d random samples over %0d register settings.",
             directed_cnt, random_cnt, settings_cnt);
    $display("%0d results clamped; included a %0d-cycle result hold-off and a full drain pause.",
             clamped_cnt, HoldCycles);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
